// ===== hdl/rse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Widths, reset values, register indexes and divider handshake types for the
// record start and rate estimator.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int FRAC_BITS = 16;

    localparam int SPR_W    = 11;
    localparam int PERIOD_W = 40;
    localparam int GAIN_W   = 16;
    localparam int SAMPLE_W = 32;
    localparam int TS_W     = 52;
    localparam int RATE_W   = 32;
    localparam int SUM_W    = 62;
    localparam int PROD_W   = PERIOD_W + GAIN_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;

    // microseconds per second
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

    // shared divider sizing
    localparam int DIV_W      = SUM_W + FRAC_BITS;
    localparam int DSR_W      = PERIOD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int PER_DVD_W  = PERIOD_W + 1;
    localparam int RATE_DVD_W = US_W + 2 * FRAC_BITS;

    localparam logic [63:0] FRAC_HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] GAIN_HALF = 64'd1 << (GAIN_W - 1);

    localparam logic [SPR_W-1:0]    SPR_RESET  = 11'd114;
    localparam logic [PERIOD_W-1:0] INIT_RESET = 40'd372958466540;
    localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd55;
    localparam logic [SAMPLE_W-1:0] SMIN_RESET = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] SMAX_RESET = 32'h7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLES_PER_RECORD = 8'd0,
        REG_INITIAL_WINDOW     = 8'd1,
        REG_DECAY_GAIN         = 8'd2,
        REG_SAMPLE_MIN         = 8'd3,
        REG_SAMPLE_MAX         = 8'd4
    } t_cfg_reg;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;   // left aligned
        logic [DSR_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hdl/rse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface rse_in_if;
    import rse_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [TS_W-1:0]            timestamp_us;
    logic                       read_failed;

    modport source (output valid, output sample_value, output timestamp_us,
                    output read_failed, input ready);
    modport sink   (input valid, input sample_value, input timestamp_us,
                    input read_failed, output ready);
endinterface

interface rse_out_if;
    import rse_pkg::*;
    logic                valid;
    logic                ready;
    logic [TS_W-1:0]     record_start_us;
    logic [PERIOD_W-1:0] sample_period_q16;
    logic [RATE_W-1:0]   sample_rate_q16;
    logic                bad_sample;

    modport source (output valid, output record_start_us, output sample_period_q16,
                    output sample_rate_q16, output bad_sample, input ready);
    modport sink   (input valid, input record_start_us, input sample_period_q16,
                    input sample_rate_q16, input bad_sample, output ready);
endinterface

interface rse_cfg_if;
    import rse_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/record_start_and_rate_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_start_and_rate_estimator
// Estimates record start time, sample period and sample rate from
// timestamped samples grouped into records.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries one sample per transaction; o_result carries one result
//   per finished record, or one error result for a bad sample. i_cfg writes
//   the five registers by index; it is taken only while the block is idle.
//   A sample that does not end a record is accepted, with the shared
//   multiplier forming period times index, and then accumulated before the
//   next sample can be taken. After the last sample of a record the block
//   makes three passes through the bit-serial divider (78, 41 and 52
//   quotient bits for the average, the period and the rate), with the filter
//   between the first two (skipped for the first record), before the next
//   sample is taken. A bad sample, a write of the record length or the
//   initial window, and reset each restart the estimator, which then runs
//   the period division before i_sample is ready again.
//   The result sits in an output register; while the receiver stalls the
//   block keeps taking samples and only waits when a new result is due.
// ----------------------------------------------------------------------------
module record_start_and_rate_estimator #(
    parameter int MAX_RECORD_SAMPLES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rse_cfg_if.sink   i_cfg,
    rse_in_if.sink    i_sample,
    rse_out_if.source o_result
);
    import rse_pkg::*;

    localparam int LEN_W = $clog2(MAX_RECORD_SAMPLES + 1);
    localparam int IDX_W = $clog2(MAX_RECORD_SAMPLES);
    localparam int CMP_W = (LEN_W > SPR_W) ? LEN_W : SPR_W;

    typedef enum logic [13:0] {
        S_IDLE      = 14'h0001,
        S_ACC       = 14'h0002,
        S_AVG_GO    = 14'h0004,
        S_AVG_WAIT  = 14'h0008,
        S_CUR       = 14'h0010,
        S_FMUL      = 14'h0020,
        S_FADD      = 14'h0040,
        S_START     = 14'h0080,
        S_PER_GO    = 14'h0100,
        S_PER_WAIT  = 14'h0200,
        S_RATE_GO   = 14'h0400,
        S_RATE_WAIT = 14'h0800,
        S_EMIT      = 14'h1000,
        S_ERR       = 14'h2000
    } t_state;

    t_state r_state;

    // registers
    logic [SPR_W-1:0]           r_spr;
    logic [PERIOD_W-1:0]        r_init;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [SAMPLE_W-1:0] r_smin;
    logic signed [SAMPLE_W-1:0] r_smax;

    // estimator state
    logic [IDX_W-1:0]    r_idx;
    logic [SUM_W-1:0]    r_sum;
    logic [PERIOD_W-1:0] r_window;
    logic [PERIOD_W-1:0] r_period;
    logic [TS_W-1:0]     r_prev;
    logic                r_have;

    // working registers
    logic [TS_W-1:0]     r_ts;
    logic [PROD_W-1:0]   r_prod;
    logic                r_acc;
    logic                r_rec;
    logic [PERIOD_W-1:0] r_cur;
    logic                r_up;
    logic [RATE_W-1:0]   r_rate;

    // output register
    logic                r_out_valid;
    logic [TS_W-1:0]     r_out_start;
    logic [PERIOD_W-1:0] r_out_period;
    logic [RATE_W-1:0]   r_out_rate;
    logic                r_out_err;

    logic [TS_W-1:0]     n_start;
    logic [PERIOD_W-1:0] n_cur;
    logic [PERIOD_W-1:0] n_window;
    logic [SUM_W-1:0]    n_sum;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // record length clamp
    logic [CMP_W-1:0] spr_ext;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] half_len;
    logic [LEN_W-1:0] cnt_len;

    assign spr_ext = CMP_W'(r_spr);

    always_comb begin
        if (spr_ext < CMP_W'(2)) begin
            len = LEN_W'(2);
        end else if (spr_ext > CMP_W'(MAX_RECORD_SAMPLES)) begin
            len = LEN_W'(MAX_RECORD_SAMPLES);
        end else begin
            len = LEN_W'(spr_ext);
        end
    end

    assign half_len = len >> 1;
    assign cnt_len  = len - half_len;

    // handshakes
    logic cfg_fire;
    logic in_fire;
    logic in_err;
    logic out_free;
    logic cfg_restart;

    assign i_cfg.ready    = (r_state == S_IDLE);
    assign i_sample.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign cfg_fire       = i_cfg.valid && i_cfg.ready;
    assign in_fire        = i_sample.valid && i_sample.ready;
    assign in_err         = i_sample.read_failed
                            || (i_sample.sample_value < r_smin)
                            || (i_sample.sample_value > r_smax);
    assign out_free       = !r_out_valid || o_result.ready;
    assign cfg_restart    = cfg_fire && ((i_cfg.index == REG_SAMPLES_PER_RECORD)
                                         || (i_cfg.index == REG_INITIAL_WINDOW));

    // shared multiplier: period * index while accepting, gain * |cur - w| in filter
    logic [PERIOD_W-1:0] mul_a;
    logic [GAIN_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PERIOD_W-1:0] diff;
    logic                up_c;

    assign up_c = r_cur >= r_window;
    assign diff = up_c ? (r_cur - r_window) : (r_window - r_cur);

    always_comb begin
        if (r_state == S_FMUL) begin
            mul_a = diff;
            mul_b = r_gain;
        end else begin
            mul_a = r_period;
            mul_b = GAIN_W'(r_idx);
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // accumulate the start term
    logic [PROD_W:0]  sub_rnd;
    logic [TS_W-1:0]  sub;
    logic [TS_W-1:0]  term;
    logic [SUM_W:0]   sum_wide;

    assign sub_rnd  = (PROD_W + 1)'(r_prod) + (PROD_W + 1)'(FRAC_HALF);
    assign sub      = TS_W'(sub_rnd >> FRAC_BITS);
    assign term     = (r_ts >= sub) ? (r_ts - sub) : '0;
    assign sum_wide = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(term);
    assign n_sum    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    logic [LEN_W:0] idx_next;
    logic           rec_more;

    assign idx_next = (LEN_W + 1)'(r_idx) + (LEN_W + 1)'(1);
    assign rec_more = idx_next < (LEN_W + 1)'(len);

    // record end: average quotient with fraction bits below it
    logic [SUM_W-1:0]     avg_q;
    logic [FRAC_BITS-1:0] avg_frac;
    logic [SUM_W-1:0]     prev_ext;
    logic [SUM_W-1:0]     avg_gap;

    assign avg_q    = div_rsp.quotient[DIV_W-1:FRAC_BITS];
    assign avg_frac = div_rsp.quotient[FRAC_BITS-1:0];
    assign prev_ext = SUM_W'(r_prev);
    assign avg_gap  = avg_q - prev_ext;

    always_comb begin
        if (avg_q < prev_ext) begin
            n_cur = '0;
        end else if (avg_gap[SUM_W-1:PERIOD_W-FRAC_BITS] != '0) begin
            n_cur = {PERIOD_W{1'b1}};
        end else begin
            n_cur = {avg_gap[PERIOD_W-FRAC_BITS-1:0], avg_frac};
        end
    end

    logic [PROD_W:0]     gain_rnd;
    logic [PERIOD_W-1:0] delta;

    assign gain_rnd = (PROD_W + 1)'(r_prod) + (PROD_W + 1)'(GAIN_HALF);
    assign delta    = gain_rnd[GAIN_W+PERIOD_W-1:GAIN_W];
    assign n_window = r_up ? (r_window + delta) : (r_window - delta);

    logic [PERIOD_W:0] win_rnd;

    assign win_rnd = (PERIOD_W + 1)'(r_window) + (PERIOD_W + 1)'(FRAC_HALF);
    assign n_start = r_have ? (r_prev + TS_W'(win_rnd[PERIOD_W:FRAC_BITS]))
                            : avg_q[TS_W-1:0];

    // divider requests
    logic [PER_DVD_W-1:0] per_dvd;

    assign per_dvd = PER_DVD_W'(r_window) + PER_DVD_W'(half_len);

    always_comb begin
        div_req = '0;
        case (r_state)
            S_AVG_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_sum, {FRAC_BITS{1'b0}}};
                div_req.divisor  = DSR_W'(cnt_len);
                div_req.steps    = DIV_CNT_W'(DIV_W);
            end
            S_PER_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(per_dvd) << (DIV_W - PER_DVD_W);
                div_req.divisor  = DSR_W'(len);
                div_req.steps    = DIV_CNT_W'(PER_DVD_W);
            end
            S_RATE_GO: begin
                div_req.start    = (r_period != '0);
                div_req.dividend = DIV_W'(US_PER_S) << (DIV_W - US_W);
                div_req.divisor  = r_period;
                div_req.steps    = DIV_CNT_W'(RATE_DVD_W);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    rse_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PER_GO;
            r_spr       <= SPR_RESET;
            r_init      <= INIT_RESET;
            r_gain      <= GAIN_RESET;
            r_smin      <= SMIN_RESET;
            r_smax      <= SMAX_RESET;
            r_idx       <= '0;
            r_sum       <= '0;
            r_window    <= INIT_RESET;
            r_period    <= '0;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_acc       <= 1'b0;
            r_rec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (((r_state == S_EMIT) || (r_state == S_ERR)) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cfg_fire) begin
                        case (i_cfg.index)
                            REG_SAMPLES_PER_RECORD: r_spr <= i_cfg.data[SPR_W-1:0];
                            REG_INITIAL_WINDOW:     r_init <= i_cfg.data[PERIOD_W-1:0];
                            REG_DECAY_GAIN:         r_gain <= i_cfg.data[GAIN_W-1:0];
                            REG_SAMPLE_MIN:         r_smin <= i_cfg.data[SAMPLE_W-1:0];
                            REG_SAMPLE_MAX:         r_smax <= i_cfg.data[SAMPLE_W-1:0];
                            default: ;
                        endcase
                        if (cfg_restart) begin
                            r_rec   <= 1'b0;
                            r_state <= S_PER_GO;
                        end
                    end else if (in_fire) begin
                        if (in_err) begin
                            r_state <= S_ERR;
                        end else begin
                            r_acc   <= (LEN_W'(r_idx) >= half_len);
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (r_acc) begin
                        r_sum <= n_sum;
                    end
                    if (rec_more) begin
                        r_idx   <= IDX_W'(idx_next);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_AVG_GO;
                    end
                end
                S_AVG_GO: begin
                    r_state <= S_AVG_WAIT;
                end
                S_AVG_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= S_CUR;
                    end
                end
                S_CUR: begin
                    r_cur   <= n_cur;
                    // the first record keeps the starting window
                    r_state <= r_have ? S_FMUL : S_START;
                end
                S_FMUL: begin
                    r_up    <= up_c;
                    r_state <= S_FADD;
                end
                S_FADD: begin
                    r_window <= n_window;
                    r_state  <= S_START;
                end
                S_START: begin
                    r_prev  <= n_start;
                    r_have  <= 1'b1;
                    r_idx   <= '0;
                    r_sum   <= '0;
                    r_rec   <= 1'b1;
                    r_state <= S_PER_GO;
                end
                S_PER_GO: begin
                    r_state <= S_PER_WAIT;
                end
                S_PER_WAIT: begin
                    if (div_rsp.done) begin
                        r_period <= div_rsp.quotient[PERIOD_W-1:0];
                        r_state  <= r_rec ? S_RATE_GO : S_IDLE;
                    end
                end
                S_RATE_GO: begin
                    if (r_period == '0) begin
                        r_rate  <= {RATE_W{1'b1}};
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RATE_WAIT;
                    end
                end
                S_RATE_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient[RATE_DVD_W-1:RATE_W] != '0) begin
                            r_rate <= {RATE_W{1'b1}};
                        end else begin
                            r_rate <= div_rsp.quotient[RATE_W-1:0];
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_rec   <= 1'b0;
                        r_state <= S_PER_GO;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // restart from the current registers
            if (cfg_restart || (in_fire && in_err)) begin
                r_idx    <= '0;
                r_sum    <= '0;
                r_prev   <= '0;
                r_have   <= 1'b0;
                if (cfg_fire && (i_cfg.index == REG_INITIAL_WINDOW)) begin
                    r_window <= i_cfg.data[PERIOD_W-1:0];
                end else begin
                    r_window <= r_init;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_fire) begin
            r_ts   <= i_sample.timestamp_us;
            r_prod <= mul_p;
        end else if (r_state == S_FMUL) begin
            r_prod <= mul_p;
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_start  <= r_prev;
            r_out_period <= r_period;
            r_out_rate   <= r_rate;
            r_out_err    <= 1'b0;
        end else if ((r_state == S_ERR) && out_free) begin
            r_out_start  <= '0;
            r_out_period <= '0;
            r_out_rate   <= '0;
            r_out_err    <= 1'b1;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.record_start_us   = r_out_start;
    assign o_result.sample_period_q16 = r_out_period;
    assign o_result.sample_rate_q16   = r_out_rate;
    assign o_result.bad_sample        = r_out_err;

endmodule

// ===== hdl/rse_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_divider
// Shared restoring divider, one quotient bit per cycle. The dividend comes in
// left aligned and steps gives how many of its bits to consume.
// ----------------------------------------------------------------------------
module rse_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rse_pkg::t_div_req i_req,
    output rse_pkg::t_div_rsp o_rsp
);
    import rse_pkg::*;

    logic [DSR_W-1:0]     r_rem;
    logic [DSR_W-1:0]     r_dsr;
    logic [DIV_W-1:0]     r_dvd;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DSR_W:0] trial;
    logic [DSR_W:0] trial_sub;
    logic           fit;

    assign trial     = {r_rem, r_dvd[DIV_W-1]};
    assign trial_sub = trial - {1'b0, r_dsr};
    assign fit       = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 40 bits hold it
            r_rem <= fit ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[DIV_W-2:0], fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
